// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Plain text macros; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: label");

// When pre holds, post must hold on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: label");

`endif

// ===== hdl/pslt_pkg.sv =====
// Package for the per-source latest-time median block: sizes, codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pslt_pkg;

   localparam int MAX_SOURCES = 16;
   localparam int IDX_W       = $clog2(MAX_SOURCES);
   localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
   localparam int TIME_W      = 64;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [CNT_W-1:0] SOURCE_COUNT_RESET = CNT_W'(4);
   // register index as decoded from paddr[2]
   localparam logic REG_SOURCE_COUNT = 1'b0;

   typedef enum logic [1:0] {
      ST_STORED    = 2'd0,
      ST_NOT_NEWER = 2'd1,
      ST_BAD_SIG   = 2'd2,
      ST_UNKNOWN   = 2'd3
   } status_type;

   // sorter control from the sequencer
   typedef struct packed {
      logic             clear;
      logic             insert;
      logic [IDX_W-1:0] sel_idx;
   } sort_ctl_type;

endpackage
`default_nettype wire

// ===== hdl/pslt_store.sv =====
// Timestamp store: one synchronous memory, one read and one write port,
// registered read. Valid bits make unwritten entries read as zero.
// Depends on pslt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pslt_store import pslt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [TIME_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [TIME_W-1:0] wr_data
);

   logic [TIME_W-1:0]      time_mem [MAX_SOURCES];
   logic [TIME_W-1:0]      q_ff;
   logic                   q_valid_ff;
   logic [MAX_SOURCES-1:0] valid_ff;

   // memory array, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= time_mem[rd_addr];
      end
   end

   // per-entry valid bits, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            q_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = q_valid_ff ? q_ff : '0;

endmodule
`default_nettype wire

// ===== hdl/pslt_sorter.sv =====
// Insertion sorter: a row of lanes kept in ascending order, one value
// inserted per cycle, one lane read out by index.
// Depends on pslt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pslt_sorter import pslt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  sort_ctl_type      ctl,
   input  logic [TIME_W-1:0] ins_data,
   output logic [TIME_W-1:0] sel_data
);

   logic [TIME_W-1:0]      lane_ff [MAX_SOURCES];
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [MAX_SOURCES-1:0] gt;

   // lanes past the fill level act as +infinity
   always_comb begin
      for (int k = 0; k < MAX_SOURCES; k++) begin
         gt[k] = (CNT_W'(k) >= fill_ff) || (lane_ff[k] > ins_data);
      end
   end

   // each lane above the insert point takes its lower neighbor
   for (genvar k = 0; k < MAX_SOURCES; k++) begin : g_lane
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (ctl.insert && gt[k]) begin
               lane_ff[k] <= ins_data;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (ctl.insert && gt[k]) begin
               lane_ff[k] <= gt[k-1] ? lane_ff[k-1] : ins_data;
            end
         end
      end
   end

   // fill level
   always_comb begin
      fill_in = fill_ff;
      if (ctl.clear) begin
         fill_in = '0;
      end else if (ctl.insert) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign sel_data = lane_ff[ctl.sel_idx];

endmodule
`default_nettype wire

// ===== hdl/per_source_latest_time_median.sv =====
// Channel  Dir  Ports           Contents
// req      in   req_t*          tdata: source_index, sample_time; tuser: signature_ok
// rsp      out  rsp_t*          tdata: median_time; tuser: update_status
// csr      in   csr_p*          APB, register 0 = source_count (byte address 0)
//
// One request at a time. With n = min(source_count, 16), the median pass
// scans n entries; the next request can be taken in the same cycle as
// the result appears. The scan time is set by the single read port of the
// timestamp memory, which the median pass scans one entry per cycle.
// Reset is synchronous; entries read as zero until written.
// A stalled result holds in the output register; a new request is taken
// meanwhile and its result waits until the previous one is taken.
//
// Top level: sequencer, configuration register, output register.
// Depends on pslt_pkg, pslt_store, pslt_sorter.
`timescale 1ns / 1ps
`default_nettype none
module per_source_latest_time_median import pslt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [71:0]       req_tdata,   // [3:0] source_index, [67:4] sample_time, zero fill
   input  logic [0:0]        req_tuser,   // [0] signature_ok
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,   // [63:0] median_time
   output logic [1:0]        rsp_tuser,   // [1:0] update_status
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_CHECK   = 7'b0000010,
      S_SCAN    = 7'b0000100,
      S_TAIL    = 7'b0001000,
      S_PICK_LO = 7'b0010000,
      S_PICK_HI = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  live;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              sig_ff, sig_in;
   status_type        status_ff, status_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [TIME_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] rsp_data_ff, rsp_data_in;
   status_type        rsp_user_ff, rsp_user_in;

   logic              req_acc, known, load;
   logic              rd_en, wr_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [TIME_W-1:0] rd_data, sel_data, median;
   sort_ctl_type      sort_ctl;

   // configuration register
   assign csr_pready = 1'b1;
   assign live = (count_ff > CNT_W'(MAX_SOURCES)) ? CNT_W'(MAX_SOURCES) : count_ff;

   always_comb begin
      count_in = count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == REG_SOURCE_COUNT) begin
         count_in = csr_pwdata[CNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SOURCE_COUNT)
                       ? {{(CSR_DW-CNT_W){1'b0}}, count_ff} : '0;

   // request handshake
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign known      = ({1'b0, idx_ff} < live);

   // memory access
   assign rd_en   = req_acc || (state_ff == S_SCAN);
   assign rd_addr = (state_ff == S_SCAN) ? scan_ff : req_tdata[IDX_W-1:0];
   assign wr_en   = (state_ff == S_CHECK) && known && sig_ff && (time_ff > rd_data);

   pslt_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (time_ff)
   );

   // sorter control
   always_comb begin
      sort_ctl.clear   = (state_ff == S_CHECK);
      sort_ctl.insert  = pend_ff;
      sort_ctl.sel_idx = IDX_W'(live >> 1);
      if (state_ff == S_PICK_LO) begin
         sort_ctl.sel_idx = IDX_W'((live - CNT_W'(1)) >> 1);
      end
   end

   pslt_sorter u_sorter (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sort_ctl),
      .ins_data (rd_data),
      .sel_data (sel_data)
   );

   // average of the two middle values without overflow
   assign median = (live == '0) ? '0
                 : (lo_ff >> 1) + (hi_ff >> 1) + TIME_W'(lo_ff[0] & hi_ff[0]);
   assign load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      time_in      = time_ff;
      sig_in       = sig_ff;
      status_in    = status_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               idx_in   = req_tdata[IDX_W-1:0];
               time_in  = req_tdata[IDX_W +: TIME_W];
               sig_in   = req_tuser[0];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!known) begin
               status_in = ST_UNKNOWN;
            end else if (!sig_ff) begin
               status_in = ST_BAD_SIG;
            end else if (time_ff > rd_data) begin
               status_in = ST_STORED;
            end else begin
               status_in = ST_NOT_NEWER;
            end
            scan_in  = '0;
            state_in = (live == '0) ? S_FINISH : S_SCAN;
         end
         S_SCAN: begin
            pend_in = 1'b1;
            if ({1'b0, scan_ff} == live - CNT_W'(1)) begin
               state_in = S_TAIL;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         S_TAIL: begin
            state_in = S_PICK_LO;
         end
         S_PICK_LO: begin
            lo_in    = sel_data;
            state_in = S_PICK_HI;
         end
         S_PICK_HI: begin
            hi_in    = sel_data;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (load) begin
               rsp_data_in  = median;
               rsp_user_in  = status_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= SOURCE_COUNT_RESET;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      time_ff     <= time_in;
      sig_ff      <= sig_in;
      status_ff   <= status_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ===== hdl/pslt_checker.sv =====
// Port-level checker for the per-source latest-time median block, bound
// to the top level. Depends on pslt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pslt_checker import pslt_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [63:0]       rsp_tdata,
   input wire logic [1:0]        rsp_tuser,
   input wire logic              csr_pready
);

   // a held response keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one request at a time: no request taken right after another
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   // no result rises in the cycle after a request is taken
   `ASSERT_NEXT(a_no_idle_result, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid))

   // the configuration port never waits
   `ASSERT_ALWAYS(a_pready, clock, reset, csr_pready)

endmodule

bind per_source_latest_time_median pslt_checker u_pslt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);
`default_nettype wire
